@@ src/rc4sc_pkg.sv @@
package rc4sc_pkg;

  localparam int PERM_DEPTH        = 256;
  localparam int MAX_KEY_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN_A,
    ST_GEN_B,
    ST_GEN_C,
    ST_GEN_D,
    ST_GEN_HOLD,
    ST_KS_RD,
    ST_KS_RJ,
    ST_KS_WN,
    ST_KS_WJ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic key_load;
    logic ks_start;
    logic clear;
    logic data_start;
    logic gen_a;
    logic gen_b;
    logic gen_c;
    logic gen_d;
    logic ks_1;
    logic ks_2;
    logic ks_3;
    logic ks_4;
    logic push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ks_last;
    logic out_busy;
  } sts_t;

endpackage

@@ src/rc4sc_ctrl.sv @@
module rc4sc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      func,
  input  logic            last,
  input  rc4sc_pkg::sts_t sts,
  output logic            in_ready,
  output rc4sc_pkg::cmd_t cmd
);
  import rc4sc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_DATA) begin
            state_nxt = ST_GEN_A;
          end else if (func == FUNC_KEY && last) begin
            state_nxt = ST_KS_RD;
          end
        end
      end
      ST_GEN_A:    state_nxt = ST_GEN_B;
      ST_GEN_B:    state_nxt = ST_GEN_C;
      ST_GEN_C:    state_nxt = ST_GEN_D;
      ST_GEN_D:    state_nxt = sts.out_busy ? ST_GEN_HOLD : ST_IDLE;
      ST_GEN_HOLD: state_nxt = sts.out_busy ? ST_GEN_HOLD : ST_IDLE;
      ST_KS_RD:    state_nxt = ST_KS_RJ;
      ST_KS_RJ:    state_nxt = ST_KS_WN;
      ST_KS_WN:    state_nxt = ST_KS_WJ;
      ST_KS_WJ:    state_nxt = sts.ks_last ? ST_IDLE : ST_KS_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.key_load   = (func == FUNC_KEY);
          cmd.ks_start   = (func == FUNC_KEY) && last;
          cmd.clear      = (func == FUNC_CLEAR);
          cmd.data_start = (func == FUNC_DATA);
        end
      end
      ST_GEN_A: cmd.gen_a = 1'b1;
      ST_GEN_B: cmd.gen_b = 1'b1;
      ST_GEN_C: cmd.gen_c = 1'b1;
      ST_GEN_D: begin
        cmd.gen_d = 1'b1;
        cmd.push  = !sts.out_busy;
      end
      ST_GEN_HOLD: cmd.push = !sts.out_busy;
      ST_KS_RD: cmd.ks_1 = 1'b1;
      ST_KS_RJ: cmd.ks_2 = 1'b1;
      ST_KS_WN: cmd.ks_3 = 1'b1;
      ST_KS_WJ: cmd.ks_4 = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/rc4sc_dp.sv @@
module rc4sc_dp #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rc4sc_pkg::cmd_t cmd,
  input  logic [7:0]      in_byte,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic [7:0]      out_tdata,
  output rc4sc_pkg::sts_t sts
);
  import rc4sc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // permutation memory; entries not yet written read as zero or as their index
  logic [7:0]            perm_mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] vld_r, vld_nxt;
  logic                  ident_r, ident_nxt;
  logic [7:0]            mem_q, raddr_q;
  logic                  vld_q;

  logic [7:0]            key_mem [MAX_KEY_BYTES];
  logic [7:0]            key_q;

  logic [7:0]            i_r, i_nxt, j_r, j_nxt;
  logic [KIDX_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      k_inc;
  logic [7:0]            si_r, sj_r, t_r, byte_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r;

  logic                  rd_en, wr_en, key_we;
  logic [7:0]            raddr, waddr, wdata, rd_data, ks;

  assign rd_data = vld_q ? mem_q : (ident_r ? raddr_q : 8'h00);
  assign key_we  = cmd.key_load && (count_r < CNT_W'(MAX_KEY_BYTES));
  assign k_inc   = CNT_W'(k_r) + 1'b1;

  // swapped entries are forwarded, everything else comes from the read
  assign ks = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : rd_data);

  assign sts.ks_last  = (i_r == 8'hFF);
  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    raddr = i_r;
    waddr = i_r;
    wdata = rd_data;
    if (cmd.gen_a) begin
      rd_en = 1'b1;
      raddr = i_r + 8'd1;
    end
    if (cmd.gen_b) begin
      rd_en = 1'b1;
      raddr = j_r + rd_data;
    end
    if (cmd.gen_c) begin
      rd_en = 1'b1;
      raddr = si_r + rd_data;
      wr_en = 1'b1;
      waddr = i_r;
      wdata = rd_data;
    end
    if (cmd.gen_d || cmd.ks_4) begin
      wr_en = 1'b1;
      waddr = j_r;
      wdata = si_r;
    end
    if (cmd.ks_1) begin
      rd_en = 1'b1;
      raddr = i_r;
    end
    if (cmd.ks_2) begin
      rd_en = 1'b1;
      raddr = j_r + rd_data + key_q;
    end
    if (cmd.ks_3) begin
      wr_en = 1'b1;
      waddr = i_r;
      wdata = rd_data;
    end
  end

  always_comb begin
    vld_nxt       = vld_r;
    ident_nxt     = ident_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (key_we) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.clear || cmd.ks_start) begin
      vld_nxt   = '0;
      ident_nxt = cmd.ks_start;
      i_nxt     = 8'd0;
      j_nxt     = 8'd0;
      k_nxt     = '0;
    end
    if (wr_en) begin
      vld_nxt[waddr] = 1'b1;
    end
    if (cmd.gen_a) begin
      i_nxt = i_r + 8'd1;
    end
    if (cmd.gen_b) begin
      j_nxt = j_r + rd_data;
    end
    if (cmd.ks_2) begin
      j_nxt = j_r + rd_data + key_q;
    end
    if (cmd.ks_4) begin
      i_nxt = i_r + 8'd1;
      k_nxt = (k_inc == count_r) ? '0 : KIDX_W'(k_inc);
      if (sts.ks_last) begin
        j_nxt     = 8'd0;
        count_nxt = '0;
      end
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      ident_r     <= 1'b0;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      k_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      ident_r     <= ident_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_b || cmd.ks_2) begin
      si_r <= rd_data;
    end
    if (cmd.gen_c) begin
      sj_r <= rd_data;
      t_r  <= si_r + rd_data;
    end
    if (cmd.data_start) begin
      byte_r <= in_byte;
    end
    if (cmd.push) begin
      out_data_r <= byte_r ^ ks;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q   <= perm_mem[raddr];
      vld_q   <= vld_r[raddr];
      raddr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[count_r[KIDX_W-1:0]] <= in_byte;
    end
    if (cmd.ks_1) begin
      key_q <= key_mem[k_r];
    end
  end

endmodule

@@ src/rc4_stream_cipher.sv @@
// Key and clear words leave the engine idle. Data word: states A, B, C, D, then a
// hold while output stalls, before the next accept; set by the single read port of
// the permutation memory (three reads and two writes per keystream byte). Last key
// word: key schedule over 256 entries, each step reading i and j, writing i and j.
// Reset (rst_n low, synchronous) empties the permutation to all zeros at once
// through per-entry valid bits; no clearing pass.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic [1:0] in_tuser,   // [1:0] func
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] out_byte
);
  import rc4sc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4sc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .func     (in_tuser),
    .last     (in_tlast),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  rc4sc_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

  // a data word keeps the engine busy
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_DATA) |=> !in_tready)
    else $error("data word did not start the generator");

  // last key word starts the key schedule
  a_ks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_KEY && in_tlast) |=> !in_tready)
    else $error("key schedule did not start");

  // clear leaves the engine ready again in the next cycle
  a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_CLEAR) |=> in_tready)
    else $error("clear did not return to idle");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !(out_tvalid && !out_tready))
    else $error("result pushed over a pending word");

endmodule
